// ===== rtl/apt_pkg.sv =====
// apt_pkg: operation classes, status codes and register indexes of the
// affine point transform. No dependencies.
package apt_pkg;

	typedef enum logic [2:0] {
		OP_PASS    = 3'd0,
		OP_FWD_RS  = 3'd1,
		OP_FWD_GEN = 3'd2,
		OP_INV_RS  = 3'd3,
		OP_INV_GEN = 3'd4
	} apt_op_t;

	typedef struct packed {
		apt_op_t op;
		logic    uni;
		logic    zs;
	} apt_ctl_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	localparam logic [2:0] CFG_ROW0  = 3'd0;
	localparam logic [2:0] CFG_ROW1  = 3'd1;
	localparam logic [2:0] CFG_ROW2  = 3'd2;
	localparam logic [2:0] CFG_SCALE = 3'd3;
	localparam logic [2:0] CFG_FLAGS = 3'd4;

	localparam int FLAG_IDENT = 0;
	localparam int FLAG_RS    = 1;
	localparam int FLAG_UNI   = 2;

	localparam int CFG_DATA_W = 64;
	localparam int SCALE_W    = 48;
	localparam int FLAGS_W    = 3;

endpackage

// ===== rtl/apt_if.sv =====
// apt_in_if / apt_out_if: valid/ready channels for points and results.
// Standalone; widths follow W.
interface apt_in_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic                func;
	logic signed [W-1:0] in_x;
	logic signed [W-1:0] in_y;
	logic signed [W-1:0] in_z;
	modport source (output valid, func, in_x, in_y, in_z, input ready);
	modport sink (input valid, func, in_x, in_y, in_z, output ready);
endinterface

interface apt_out_if #(parameter int W = 16) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] out_x;
	logic signed [W-1:0] out_y;
	logic signed [W-1:0] out_z;
	logic [1:0]          status;
	modport source (output valid, out_x, out_y, out_z, status, input ready);
	modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// ===== rtl/apt_front.sv =====
// apt_front: configuration registers, entry extraction and item classification.
// Depends on apt_pkg and apt_in_if.
module apt_front import apt_pkg::*; #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	apt_in_if.sink                in_ch,
	output logic                  push_valid,
	input  logic                  push_ready,
	output apt_ctl_t              push_ctl,
	output logic signed [W-1:0]   push_x,
	output logic signed [W-1:0]   push_y,
	output logic signed [W-1:0]   push_z,
	output logic signed [W-1:0]   mat [3][3],
	output logic signed [W-1:0]   trans [3],
	output logic signed [W-1:0]   scale [3]
);

	localparam logic [W-1:0] ONE_W = W'(1) << F;
	localparam logic [CFG_DATA_W-1:0] ONE64 = CFG_DATA_W'(ONE_W);

	logic [CFG_DATA_W-1:0] row_q [3];
	logic [SCALE_W-1:0]    scale_q;
	logic [FLAGS_W-1:0]    flags_q;

	logic [4*W+CFG_DATA_W-1:0] rext [3];
	logic [3*W+SCALE_W-1:0]    sext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) row_q[r] <= ONE64 << (r * W);
			scale_q <= SCALE_W'(ONE64 | (ONE64 << W) | (ONE64 << (2 * W)));
			flags_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROW0:  row_q[0] <= cfg_data;
				CFG_ROW1:  row_q[1] <= cfg_data;
				CFG_ROW2:  row_q[2] <= cfg_data;
				CFG_SCALE: scale_q  <= cfg_data[SCALE_W-1:0];
				CFG_FLAGS: flags_q  <= cfg_data[FLAGS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sext = {(3*W)'(0), scale_q};
		for (int r = 0; r < 3; r++) begin
			rext[r] = {(4*W)'(0), row_q[r]};
			for (int c = 0; c < 3; c++) mat[r][c] = rext[r][c*W +: W];
			trans[r] = rext[r][3*W +: W];
			scale[r] = sext[r*W +: W];
		end
	end

	always_comb begin
		if (flags_q[FLAG_IDENT])
			push_ctl.op = OP_PASS;
		else if (!in_ch.func)
			push_ctl.op = flags_q[FLAG_RS] ? OP_FWD_RS : OP_FWD_GEN;
		else
			push_ctl.op = flags_q[FLAG_RS] ? OP_INV_RS : OP_INV_GEN;
		push_ctl.uni = flags_q[FLAG_UNI];
		push_ctl.zs  = flags_q[FLAG_UNI] ? (scale[0] == '0) :
			(scale[0] == '0 || scale[1] == '0 || scale[2] == '0);
	end

	assign push_valid  = in_ch.valid;
	assign in_ch.ready = push_ready;
	assign push_x      = in_ch.in_x;
	assign push_y      = in_ch.in_y;
	assign push_z      = in_ch.in_z;

endmodule

// ===== rtl/apt_queue.sv =====
// apt_queue: four-entry item queue between front and back.
// Standalone; entry width set by EW.
module apt_queue #(
	parameter int EW = 51
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  logic [EW-1:0] wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output logic [EW-1:0] rd_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [EW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign wr_ready = cnt_q != (PW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_data;
	end

endmodule

// ===== rtl/apt_back.sv =====
// apt_back: arithmetic pipeline: products, sums, rounding, a one-bit-per-stage
// divider and the saturating output register. Depends on apt_pkg, apt_out_if.
module apt_back import apt_pkg::*; #(
	parameter int W = 16,
	parameter int F = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  apt_ctl_t            q_ctl,
	input  logic signed [W-1:0] q_x,
	input  logic signed [W-1:0] q_y,
	input  logic signed [W-1:0] q_z,
	input  logic signed [W-1:0] mat [3][3],
	input  logic signed [W-1:0] trans [3],
	input  logic signed [W-1:0] scale [3],
	apt_out_if.source           out_ch
);

	localparam int W2 = 2 * W;
	localparam int AJ = 2 * W + 1;
	localparam int MW = AJ + W2;
	localparam int PR = 3 * W + 2;
	localparam int AW = 3 * W + 2 * F + 4;
	localparam int DT = 3 * W + 3;
	localparam int DV = DT + 1;
	localparam int RW = DV + W;
	localparam int NW = AW + 2;
	localparam int CW = NW + RW;
	localparam int NS = 5 + W;
	localparam logic [AW:0] HALF1 = (AW+1)'(1) << (F - 1);
	localparam logic [AW:0] HALF2 = (AW+1)'(1) << (2 * F - 1);
	localparam logic [W:0] POS_MAX = (W+1)'((1 << (W - 1)) - 1);
	localparam logic [W:0] NEG_MAX = (W+1)'(1) << (W - 1);

	function automatic logic signed [AJ-1:0] cof(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b, input logic signed [W-1:0] c,
		input logic signed [W-1:0] d);
		cof = AJ'(W2'(a) * W2'(b)) - AJ'(W2'(c) * W2'(d));
	endfunction

	logic          adv;
	logic [NS-1:0] vld_q;
	logic          out_valid_q;

	// stage 1
	logic signed [W-1:0]  p_in [3];
	logic signed [W:0]    d_c [3];
	logic signed [W2-1:0] sp_c [3];
	apt_ctl_t             ctl_s1;
	logic signed [W-1:0]  p_s1 [3];
	logic signed [W:0]    d_s1 [3];
	logic signed [W2-1:0] sp_s1 [3];
	logic signed [AJ-1:0] adj_s1 [3][3];
	logic signed [AJ-1:0] adj_c [3][3];
	// stage 2
	logic signed [AJ-1:0] ma [3][3];
	logic signed [W2-1:0] mb [3][3];
	apt_ctl_t             ctl_s2;
	logic signed [W-1:0]  p_s2 [3];
	logic signed [PR-1:0] prod_s2 [3][3];
	logic signed [PR-1:0] detp_s2 [3];
	// stage 3
	apt_ctl_t             ctl_s3;
	logic signed [W-1:0]  p_s3 [3];
	logic signed [AW-1:0] acc_s3 [3];
	logic signed [DT-1:0] det_s3;
	logic signed [AW-1:0] tterm [3];
	// stage 4
	logic signed [AW-1:0] num_c [3];
	logic signed [DT-1:0] dsg_c [3];
	apt_ctl_t             ctl_s4;
	logic                 bad_s4;
	logic                 neg_s4 [3];
	logic [AW-1:0]        nm_s4 [3];
	logic [DT-1:0]        dm_s4 [3];
	// stage 5
	logic [AW:0]          rnd_c [3];
	logic [NW-1:0]        np_c [3];
	logic [DV-1:0]        dp_c [3];
	logic                 bad_s5;
	logic                 neg_s5 [3];
	logic                 ovf_s5 [3];
	logic                 byp_s5 [3];
	logic [W-1:0]         mag_s5 [3];
	logic [RW-1:0]        rem_s5 [3];
	logic [DV-1:0]        dvs_s5 [3];
	// divider stages
	logic                 bad_s6 [W];
	logic                 neg_s6 [W][3];
	logic                 ovf_s6 [W][3];
	logic                 byp_s6 [W][3];
	logic [W-1:0]         mag_s6 [W][3];
	logic [RW-1:0]        rem_s6 [W][3];
	logic [DV-1:0]        dvs_s6 [W][3];
	logic [W-1:0]         mag_n [W][3];
	logic [RW-1:0]        rem_n [W][3];
	// output
	logic signed [W-1:0]  res_c [3];
	logic                 sat_c [3];
	logic signed [W-1:0]  res_q [3];
	logic [1:0]           status_q;

	assign adv     = !out_valid_q || out_ch.ready;
	assign q_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NS-2:0], q_valid};
			out_valid_q <= vld_q[NS-1];
		end
	end

	// stage 1: offsets, scaled point, cofactors
	always_comb begin
		p_in[0] = q_x;
		p_in[1] = q_y;
		p_in[2] = q_z;
		for (int c = 0; c < 3; c++) begin
			d_c[c]  = (W+1)'(p_in[c]) - (W+1)'(trans[c]);
			sp_c[c] = W2'(scale[c]) * W2'(p_in[c]);
		end
		adj_c[0][0] = cof(mat[1][1], mat[2][2], mat[1][2], mat[2][1]);
		adj_c[0][1] = cof(mat[0][2], mat[2][1], mat[0][1], mat[2][2]);
		adj_c[0][2] = cof(mat[0][1], mat[1][2], mat[0][2], mat[1][1]);
		adj_c[1][0] = cof(mat[1][2], mat[2][0], mat[1][0], mat[2][2]);
		adj_c[1][1] = cof(mat[0][0], mat[2][2], mat[0][2], mat[2][0]);
		adj_c[1][2] = cof(mat[0][2], mat[1][0], mat[0][0], mat[1][2]);
		adj_c[2][0] = cof(mat[1][0], mat[2][1], mat[1][1], mat[2][0]);
		adj_c[2][1] = cof(mat[0][1], mat[2][0], mat[0][0], mat[2][1]);
		adj_c[2][2] = cof(mat[0][0], mat[1][1], mat[0][1], mat[1][0]);
	end

	// stage 2: operand select per row and column
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				case (ctl_s1.op)
					OP_FWD_RS: begin
						ma[r][c] = AJ'(mat[r][c]);
						mb[r][c] = sp_s1[c];
					end
					OP_FWD_GEN: begin
						ma[r][c] = AJ'(mat[r][c]);
						mb[r][c] = W2'(p_s1[c]);
					end
					OP_INV_RS: begin
						ma[r][c] = AJ'(mat[c][r]);
						mb[r][c] = W2'(d_s1[c]);
					end
					OP_INV_GEN: begin
						ma[r][c] = adj_s1[r][c];
						mb[r][c] = W2'(d_s1[c]);
					end
					default: begin
						ma[r][c] = '0;
						mb[r][c] = '0;
					end
				endcase
			end
		end
	end

	// stage 3: translation term
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			case (ctl_s2.op)
				OP_FWD_RS:  tterm[r] = AW'(trans[r]) <<< (2 * F);
				OP_FWD_GEN: tterm[r] = AW'(trans[r]) <<< F;
				default:    tterm[r] = '0;
			endcase
		end
	end

	// stage 4: numerator and divisor selection
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (ctl_s3.op == OP_INV_GEN) begin
				num_c[r] = acc_s3[r] <<< F;
				dsg_c[r] = det_s3;
			end else begin
				num_c[r] = acc_s3[r];
				dsg_c[r] = ctl_s3.uni ? DT'(scale[0]) : DT'(scale[r]);
			end
		end
	end

	// stage 5: rounding or divider setup
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rnd_c[l] = (ctl_s4.op == OP_FWD_RS) ? (((AW+1)'(nm_s4[l]) + HALF2) >> (2 * F)) :
				(((AW+1)'(nm_s4[l]) + HALF1) >> F);
			np_c[l]  = NW'({nm_s4[l], 1'b0}) + NW'(dm_s4[l]);
			dp_c[l]  = {dm_s4[l], 1'b0};
		end
	end

	// divider: one quotient bit per stage, MSB first
	always_comb begin
		logic [RW-1:0] src_rem;
		logic [DV-1:0] src_dvs;
		logic [W-1:0]  src_mag;
		logic          src_byp;
		logic [RW-1:0] sh;
		for (int j = 0; j < W; j++) begin
			for (int l = 0; l < 3; l++) begin
				if (j == 0) begin
					src_rem = rem_s5[l];
					src_dvs = dvs_s5[l];
					src_mag = mag_s5[l];
					src_byp = byp_s5[l];
				end else begin
					src_rem = rem_s6[j-1][l];
					src_dvs = dvs_s6[j-1][l];
					src_mag = mag_s6[j-1][l];
					src_byp = byp_s6[j-1][l];
				end
				sh = RW'(src_dvs) << (W - 1 - j);
				if (!src_byp && src_rem >= sh) begin
					rem_n[j][l] = src_rem - sh;
					mag_n[j][l] = src_mag | (W'(1) << (W - 1 - j));
				end else begin
					rem_n[j][l] = src_rem;
					mag_n[j][l] = src_mag;
				end
			end
		end
	end

	// output: sign, clamp, status
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			sat_c[l] = ovf_s6[W-1][l] || (neg_s6[W-1][l] ?
				((W+1)'(mag_s6[W-1][l]) > NEG_MAX) :
				((W+1)'(mag_s6[W-1][l]) > POS_MAX));
			if (bad_s6[W-1])
				res_c[l] = '0;
			else if (sat_c[l])
				res_c[l] = neg_s6[W-1][l] ? W'(NEG_MAX) : W'(POS_MAX);
			else
				res_c[l] = neg_s6[W-1][l] ? -mag_s6[W-1][l] : mag_s6[W-1][l];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= q_ctl;
			for (int c = 0; c < 3; c++) begin
				p_s1[c]  <= p_in[c];
				d_s1[c]  <= d_c[c];
				sp_s1[c] <= sp_c[c];
				for (int r = 0; r < 3; r++) adj_s1[r][c] <= adj_c[r][c];
			end

			ctl_s2 <= ctl_s1;
			for (int r = 0; r < 3; r++) begin
				p_s2[r]    <= p_s1[r];
				detp_s2[r] <= PR'(MW'(mat[0][r]) * MW'(adj_s1[r][0]));
				for (int c = 0; c < 3; c++)
					prod_s2[r][c] <= PR'(MW'(ma[r][c]) * MW'(mb[r][c]));
			end

			ctl_s3 <= ctl_s2;
			det_s3 <= DT'(detp_s2[0]) + DT'(detp_s2[1]) + DT'(detp_s2[2]);
			for (int r = 0; r < 3; r++) begin
				p_s3[r]   <= p_s2[r];
				acc_s3[r] <= AW'(prod_s2[r][0]) + AW'(prod_s2[r][1]) +
					AW'(prod_s2[r][2]) + tterm[r];
			end

			ctl_s4 <= ctl_s3;
			bad_s4 <= (ctl_s3.op == OP_INV_RS && ctl_s3.zs) ||
				(ctl_s3.op == OP_INV_GEN && det_s3 == '0);
			for (int r = 0; r < 3; r++) begin
				if (ctl_s3.op == OP_PASS) begin
					neg_s4[r] <= p_s3[r][W-1];
					nm_s4[r]  <= p_s3[r][W-1] ? AW'(-AW'(p_s3[r])) : AW'(p_s3[r]);
				end else begin
					neg_s4[r] <= (ctl_s3.op == OP_INV_RS || ctl_s3.op == OP_INV_GEN) ?
						(num_c[r][AW-1] ^ dsg_c[r][DT-1]) : num_c[r][AW-1];
					nm_s4[r]  <= num_c[r][AW-1] ? AW'(-num_c[r]) : AW'(num_c[r]);
				end
				dm_s4[r] <= dsg_c[r][DT-1] ? DT'(-dsg_c[r]) : DT'(dsg_c[r]);
			end

			bad_s5 <= bad_s4;
			for (int l = 0; l < 3; l++) begin
				neg_s5[l] <= neg_s4[l];
				rem_s5[l] <= RW'(np_c[l]);
				dvs_s5[l] <= dp_c[l];
				case (ctl_s4.op)
					OP_PASS: begin
						mag_s5[l] <= nm_s4[l][W-1:0];
						ovf_s5[l] <= 1'b0;
						byp_s5[l] <= 1'b1;
					end
					OP_FWD_RS, OP_FWD_GEN: begin
						mag_s5[l] <= rnd_c[l][W-1:0];
						ovf_s5[l] <= rnd_c[l][AW:W] != '0;
						byp_s5[l] <= 1'b1;
					end
					default: begin
						mag_s5[l] <= '0;
						ovf_s5[l] <= CW'(np_c[l]) >= (CW'(dp_c[l]) << W);
						byp_s5[l] <= bad_s4 || (CW'(np_c[l]) >= (CW'(dp_c[l]) << W));
					end
				endcase
			end

			for (int j = 0; j < W; j++) begin
				bad_s6[j] <= (j == 0) ? bad_s5 : bad_s6[j-1];
				for (int l = 0; l < 3; l++) begin
					neg_s6[j][l] <= (j == 0) ? neg_s5[l] : neg_s6[j-1][l];
					ovf_s6[j][l] <= (j == 0) ? ovf_s5[l] : ovf_s6[j-1][l];
					byp_s6[j][l] <= (j == 0) ? byp_s5[l] : byp_s6[j-1][l];
					dvs_s6[j][l] <= (j == 0) ? dvs_s5[l] : dvs_s6[j-1][l];
					rem_s6[j][l] <= rem_n[j][l];
					mag_s6[j][l] <= mag_n[j][l];
				end
			end

			for (int l = 0; l < 3; l++) res_q[l] <= res_c[l];
			if (bad_s6[W-1])
				status_q <= ST_BAD;
			else if (sat_c[0] || sat_c[1] || sat_c[2])
				status_q <= ST_SAT;
			else
				status_q <= ST_OK;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.out_x  = res_q[0];
	assign out_ch.out_y  = res_q[1];
	assign out_ch.out_z  = res_q[2];
	assign out_ch.status = status_q;

endmodule

// ===== rtl/affine_point_transform.sv =====
// affine_point_transform: top level; front, queue and back pipeline.
// Depends on apt_pkg, apt_if, apt_front, apt_queue, apt_back.
// An item passes the arithmetic stages, the divider and the output register in turn;
// one item per cycle sustained while results are taken, set by the fully pipelined back end.
// The divider spends one stage per result bit. in ready drops when the
// four-entry queue fills. Reset restores identity matrix, unit scale, flags 7.
module affine_point_transform import apt_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	apt_in_if.sink                in_ch,
	apt_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int W   = COORD_WIDTH;
	localparam int CTW = $bits(apt_ctl_t);
	localparam int EW  = CTW + 3 * W;

	logic                push_valid;
	logic                push_ready;
	apt_ctl_t            push_ctl;
	logic signed [W-1:0] push_x;
	logic signed [W-1:0] push_y;
	logic signed [W-1:0] push_z;
	logic signed [W-1:0] mat [3][3];
	logic signed [W-1:0] trans [3];
	logic signed [W-1:0] scale [3];
	logic [EW-1:0]       rd_data;
	logic                rd_valid;
	logic                rd_ready;

	apt_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctl   (push_ctl),
		.push_x     (push_x),
		.push_y     (push_y),
		.push_z     (push_z),
		.mat        (mat),
		.trans      (trans),
		.scale      (scale)
	);

	apt_queue #(.EW(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_ctl, push_x, push_y, push_z}),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_data)
	);

	apt_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (rd_valid),
		.q_ready (rd_ready),
		.q_ctl   (apt_ctl_t'(rd_data[EW-1 -: CTW])),
		.q_x     (rd_data[3*W-1 -: W]),
		.q_y     (rd_data[2*W-1 -: W]),
		.q_z     (rd_data[W-1:0]),
		.mat     (mat),
		.trans   (trans),
		.scale   (scale),
		.out_ch  (out_ch)
	);

endmodule

// ===== rtl/apt_checker.sv =====
// apt_checker: port-level checks on the result channel, bound to the top.
// Depends on apt_pkg and affine_point_transform.
module apt_checker import apt_pkg::*; #(
	parameter int W = 16
) (
	input logic         clk,
	input logic         arst_n,
	input logic         out_valid,
	input logic         out_ready,
	input logic [W-1:0] out_x,
	input logic [W-1:0] out_y,
	input logic [W-1:0] out_z,
	input logic [1:0]   status
);

	a_no_valid_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_BAD))
		else $error("undefined status code");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BAD) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("flagged item carries nonzero coordinates");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y) &&
		$stable(out_z) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind affine_point_transform apt_checker #(.W(COORD_WIDTH)) u_apt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_x     (out_ch.out_x),
	.out_y     (out_ch.out_y),
	.out_z     (out_ch.out_z),
	.status    (out_ch.status)
);

// ===== tb/sv/tb_top.sv =====
// tb_top: regression bench for affine_point_transform; predicts every result
// in fixed point and checks each returned item. Depends on apt_pkg, apt_if and affine_point_transform.
module tb_top;
	import apt_pkg::*;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [1:0]         st;
	} point_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	apt_in_if  #(.W(16)) in_ch ();
	apt_out_if #(.W(16)) out_ch ();

	affine_point_transform #(.COORD_WIDTH(16), .FRAC_BITS(8)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam longint ACC_LIM = 64'sd1 <<< 61;

	logic [63:0] mrow [3];
	logic [47:0] scl;
	logic [2:0]  flags;
	point_res_t  pending [$];
	int errors;
	int send_idle_pct;
	int recv_idle_pct;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	function automatic longint sat_acc(longint v);
		if (v > ACC_LIM) return ACC_LIM;
		if (v < -ACC_LIM) return -ACC_LIM;
		return v;
	endfunction

	function automatic longint mul_sat(longint a, longint b);
		longint ma, mb;
		bit neg;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		if (ma != 0 && mb > ACC_LIM / ma) return neg ? -ACC_LIM : ACC_LIM;
		return neg ? -(ma * mb) : ma * mb;
	endfunction

	function automatic longint rnd_shift(longint v, int k);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (64'sd1 <<< (k - 1))) >>> k;
		return v < 0 ? -m : m;
	endfunction

	function automatic longint rnd_div(longint n, longint d);
		longint mn, md, q;
		mn = n < 0 ? -n : n;
		md = d < 0 ? -d : d;
		if (md == 0) return 0;
		q = (2 * mn + md) / (2 * md);
		if (q > ACC_LIM) q = ACC_LIM;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic point_res_t transform_point(bit inv, logic signed [15:0] px,
			logic signed [15:0] py, logic signed [15:0] pz);
		longint p [3], t [3], s [3], d [3], res [3], m [3][3], adj [3][3];
		longint acc, det, q;
		point_res_t o;
		bit sat, rs, uni;
		int k;
		logic [1:0] st;
		p[0] = px; p[1] = py; p[2] = pz;
		sat = 0;
		st = ST_OK;
		rs = flags[FLAG_RS];
		uni = flags[FLAG_UNI];
		for (int c = 0; c < 3; c++) begin
			s[c] = $signed(scl[c*16 +: 16]);
			t[c] = $signed(mrow[c][48 +: 16]);
			for (int r = 0; r < 3; r++) m[c][r] = $signed(mrow[c][r*16 +: 16]);
		end
		if (flags[FLAG_IDENT]) begin
			for (int r = 0; r < 3; r++) res[r] = p[r];
		end else if (!inv) begin
			k = rs ? 16 : 8;
			for (int r = 0; r < 3; r++) begin
				acc = mul_sat(t[r], rs ? 65536 : 256);
				for (int c = 0; c < 3; c++)
					acc = sat_acc(acc + mul_sat(m[r][c], rs ? mul_sat(s[c], p[c]) : p[c]));
				res[r] = rnd_shift(acc, k);
			end
		end else begin
			for (int c = 0; c < 3; c++) d[c] = p[c] - t[c];
			if (rs) begin
				if (uni ? s[0] == 0 : (s[0] == 0 || s[1] == 0 || s[2] == 0)) st = ST_BAD;
				for (int r = 0; r < 3; r++) begin
					q = 0;
					for (int c = 0; c < 3; c++) q = sat_acc(q + mul_sat(m[c][r], d[c]));
					res[r] = rnd_div(q, uni ? s[0] : s[r]);
				end
			end else begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						adj[r][c] = sat_acc(
							mul_sat(m[(c+1)%3][(r+1)%3], m[(c+2)%3][(r+2)%3]) -
							mul_sat(m[(c+1)%3][(r+2)%3], m[(c+2)%3][(r+1)%3]));
				det = 0;
				for (int c = 0; c < 3; c++) det = sat_acc(det + mul_sat(m[0][c], adj[c][0]));
				if (det == 0) st = ST_BAD;
				for (int r = 0; r < 3; r++) begin
					acc = 0;
					for (int c = 0; c < 3; c++) acc = sat_acc(acc + mul_sat(adj[r][c], d[c]));
					res[r] = rnd_div(mul_sat(acc, 256), det);
				end
			end
		end
		for (int r = 0; r < 3; r++) begin
			if (st == ST_BAD) res[r] = 0;
			else if (res[r] > 32767) begin res[r] = 32767; sat = 1; end
			else if (res[r] < -32768) begin res[r] = -32768; sat = 1; end
		end
		if (st != ST_BAD && sat) st = ST_SAT;
		o.x = res[0][15:0]; o.y = res[1][15:0]; o.z = res[2][15:0]; o.st = st;
		return o;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		$display("MISMATCH %0t: %s", $time, what);
	endtask

	// result checker
	always @(posedge clk) begin
		point_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending.size() == 0) begin
				report_mismatch("result with no point pending");
			end else begin
				want = pending.pop_front();
				if (out_ch.out_x !== want.x)
					report_mismatch($sformatf("x %0d want %0d", out_ch.out_x, want.x));
				if (out_ch.out_y !== want.y)
					report_mismatch($sformatf("y %0d want %0d", out_ch.out_y, want.y));
				if (out_ch.out_z !== want.z)
					report_mismatch($sformatf("z %0d want %0d", out_ch.out_z, want.z));
				if (out_ch.status !== want.st)
					report_mismatch($sformatf("status %0d want %0d", out_ch.status, want.st));
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// valid stays high after an item; idle cycles and drain drop it
	task automatic send_point(bit inv, logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= inv;
		in_ch.in_x <= px;
		in_ch.in_y <= py;
		in_ch.in_z <= pz;
		do @(posedge clk); while (!in_ch.ready);
		pending.push_back(transform_point(inv, px, py, pz));
		@(negedge clk);
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ROW0: mrow[0] = val;
			CFG_ROW1: mrow[1] = val;
			CFG_ROW2: mrow[2] = val;
			CFG_SCALE: scl = val[47:0];
			default: flags = val[2:0];
		endcase
		@(negedge clk);
	endtask

	function automatic logic [15:0] rnd_coord();
		case ($urandom_range(5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(255) - 128);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rnd_entry();
		case ($urandom_range(4))
			0: return 16'h0100;
			1: return 16'hFF00;
			2: return 16'h0000;
			3: return 16'($urandom_range(1023) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_config;
		for (int r = 0; r < 3; r++)
			write_reg(3'(r), {rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry()});
		write_reg(CFG_SCALE, {16'h0, rnd_entry(), rnd_entry(), rnd_entry()});
		write_reg(CFG_FLAGS, 64'($urandom_range(6)));
	endtask

	task automatic test_directed;
		logic [15:0] ext [4];
		ext[0] = 16'h7FFF; ext[1] = 16'h8000; ext[2] = 16'h0000; ext[3] = 16'hFFFF;
		// identity after reset
		for (int i = 0; i < 4; i++) send_point(i[0], ext[i], ext[(i+1)%4], ext[(i+2)%4]);
		drain();
		write_reg(CFG_ROW0, 64'h0100_0000_0000_0100);
		write_reg(CFG_ROW1, 64'hFF00_0000_0100_0000);
		write_reg(CFG_ROW2, 64'h7FFF_0100_0000_0000);
		write_reg(CFG_SCALE, 48'h0080_0200_0100);
		write_reg(CFG_FLAGS, 3'b010);
		send_point(0, 16'h7FFF, 16'h8000, 16'h0100);
		send_point(1, 16'h0300, 16'h8000, 16'h7FFF);
		drain();
		write_reg(CFG_FLAGS, 3'b110);
		send_point(1, 16'h0100, 16'h0200, 16'hFF00);
		drain();
		// zero scale
		write_reg(CFG_SCALE, 48'h0100_0000_0100);
		send_point(1, 16'h0100, 16'h0200, 16'hFF00);
		drain();
		write_reg(CFG_FLAGS, 3'b010);
		send_point(1, 16'h0100, 16'h0200, 16'hFF00);
		drain();
		// general and singular
		write_reg(CFG_FLAGS, 3'b000);
		send_point(0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_point(1, 16'h8000, 16'h1234, 16'h0001);
		drain();
		write_reg(CFG_ROW2, 64'h0000_0000_0000_0000);
		send_point(1, 16'h0100, 16'h0100, 16'h0100);
		send_point(0, 16'h8000, 16'h8000, 16'h8000);
		drain();
		write_reg(CFG_ROW0, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_ROW1, 64'h8000_8000_8000_8000);
		write_reg(CFG_ROW2, 64'h7FFF_7FFF_8000_7FFF);
		write_reg(CFG_SCALE, 48'hFFFF_8000_7FFF);
		send_point(0, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_point(1, 16'h8000, 16'h7FFF, 16'hFFFF);
		drain();
		write_reg(CFG_FLAGS, 3'b111);
		send_point(0, 16'h1234, 16'h8000, 16'h7FFF);
		drain();
	endtask

	task automatic test_random(int sets);
		for (int k = 0; k < sets; k++) begin
			random_config();
			repeat (35) send_point($urandom_range(1), rnd_coord(), rnd_coord(), rnd_coord());
			drain();
		end
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 12;
		recv_idle_pct = 83;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.func = 1'b0;
		in_ch.in_x = '0;
		in_ch.in_y = '0;
		in_ch.in_z = '0;
		out_ch.ready = 1'b0;
		mrow[0] = 64'h100;
		mrow[1] = 64'h100 << 16;
		mrow[2] = 64'h100 << 32;
		scl = 48'h0100_0100_0100;
		flags = 3'b111;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(10);
		send_idle_pct = 83;
		recv_idle_pct = 12;
		test_random(10);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(10);
		if (errors == 0)
			$display("affine_point_transform regression: pass");
		else
			$display("affine_point_transform regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("affine_point_transform regression: fail");
		$finish;
	end
endmodule
